[src/lrt_pkg.sv]
// Shared types and constants for the block live-range table.
// Used by lrt_front, lrt_back and block_live_range_table_core; no dependencies.
`default_nettype none
package lrt_pkg;

  localparam int VALUE_COUNT_DEF = 64;
  localparam int MAX_INSTRS_DEF  = 256;

  localparam int OP_W    = 2;
  localparam int VID_W   = 6;
  localparam int IDX_W   = 8;
  localparam int MASK_W  = 64;
  // Wide enough to hold MAX_INSTRS at its largest legal value.
  localparam int ICMP_W  = 17;

  typedef enum logic [OP_W-1:0] {
    OP_DEFINE  = 2'd0,
    OP_USE     = 2'd1,
    OP_LIVEOUT = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [VID_W-1:0] vid;
    logic [IDX_W-1:0] idx;
    logic             vid_ok;
    logic             do_upd;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic             defined;
    logic             live_out;
    logic [IDX_W-1:0] start_idx;
    logic [IDX_W-1:0] end_idx;
  } entry_t;

endpackage
`default_nettype wire

[src/lrt_front.sv]
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on lrt_pkg.
`default_nettype none
module lrt_front
  import lrt_pkg::*;
#(
  parameter int VALUE_COUNT = VALUE_COUNT_DEF,
  parameter int MAX_INSTRS  = MAX_INSTRS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OP_W-1:0]   in_operation,
  input  wire logic [VID_W-1:0]  in_value_id,
  input  wire logic [IDX_W-1:0]  in_instr_index,
  output queue_head_t            head,
  input  wire logic              pop
);

  item_t       q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  logic        do_pop;
  item_t       cls;

  always_comb begin
    cls.op     = op_t'(in_operation);
    cls.vid    = in_value_id;
    cls.idx    = in_instr_index;
    cls.vid_ok = {1'b0, in_value_id} < (VID_W+1)'(VALUE_COUNT);
    // A request only changes the table when both value and index fall in range.
    cls.do_upd = cls.vid_ok &&
                 ({{(ICMP_W-IDX_W){1'b0}}, in_instr_index} < ICMP_W'(MAX_INSTRS)) &&
                 (cls.op != OP_QUERY);
  end

  assign in_ready   = (count_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign head.valid = (count_r != 2'd0);
  assign head.item  = q_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

[src/lrt_back.sv]
// Back end: updates one table entry, then scans all entries to build the result masks.
// Depends on lrt_pkg; holds the range table memory and the present bits.
`default_nettype none
module lrt_back
  import lrt_pkg::*;
#(
  parameter int VALUE_COUNT = VALUE_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire queue_head_t       head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_value_present,
  output logic                   out_value_defined,
  output logic [MASK_W-1:0]      out_live_mask,
  output logic [MASK_W-1:0]      out_entry_mask,
  output logic [MASK_W-1:0]      out_exit_mask
);

  localparam int IDW = $clog2(VALUE_COUNT);

  state_t                  state_r, state_nxt;
  item_t                   cur_r;
  logic [IDW-1:0]          cnt_r;
  logic                    scan_v_r;
  logic [IDW-1:0]          scan_idx_r;
  logic [VALUE_COUNT-1:0]  present_r;
  entry_t                  mem [VALUE_COUNT];
  entry_t                  rdata_r;
  logic [IDW-1:0]          rd_addr;
  logic [IDW-1:0]          vidx;
  logic                    old_p;
  entry_t                  upd;
  entry_t                  eff;
  logic                    eff_p;
  logic                    last;
  logic                    scan_p;
  logic                    scan_live;

  logic                    pres_r, defd_r;
  logic [MASK_W-1:0]       live_r, entry_r, exit_r;

  assign vidx    = cur_r.vid[IDW-1:0];
  assign old_p   = present_r[vidx];
  assign last    = (cnt_r == IDW'(VALUE_COUNT - 1));
  assign rd_addr = (state_r == ST_READ) ? vidx : cnt_r;

  // New contents of the addressed entry. Fields of an absent entry are ignored.
  always_comb begin
    upd = rdata_r;
    case (cur_r.op)
      OP_DEFINE: begin
        if (!old_p) begin
          upd.live_out = 1'b0;
          upd.end_idx  = cur_r.idx;
        end
        upd.defined   = 1'b1;
        upd.start_idx = cur_r.idx;
      end
      OP_USE: begin
        if (old_p) begin
          if (!rdata_r.live_out && (rdata_r.end_idx <= cur_r.idx)) begin
            upd.end_idx = cur_r.idx;
          end
        end else begin
          upd.defined   = 1'b0;
          upd.start_idx = '0;
          upd.live_out  = 1'b0;
          upd.end_idx   = cur_r.idx;
        end
      end
      OP_LIVEOUT: begin
        if (!old_p) begin
          upd.defined   = 1'b0;
          upd.start_idx = '0;
          upd.end_idx   = '0;
        end
        upd.live_out = 1'b1;
      end
      default: begin
        upd = rdata_r;
      end
    endcase
    eff   = cur_r.do_upd ? upd : rdata_r;
    eff_p = cur_r.do_upd || old_p;
  end

  // One entry is judged per cycle with a single shared pair of comparators.
  assign scan_p    = present_r[scan_idx_r];
  assign scan_live = scan_p && (rdata_r.start_idx <= cur_r.idx) &&
                     (rdata_r.live_out || (cur_r.idx <= rdata_r.end_idx));

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_nxt = ST_OUT;
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      present_r <= '0;
      scan_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      scan_v_r <= (state_r == ST_SCAN);
      if ((state_r == ST_UPDATE) && cur_r.do_upd) begin
        present_r[vidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if ((state_r == ST_UPDATE) && cur_r.do_upd) begin
      mem[vidx] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head.item;
    end
    scan_idx_r <= cnt_r;
    case (state_r)
      ST_READ: begin
        live_r  <= '0;
        entry_r <= '0;
        exit_r  <= '0;
      end
      ST_UPDATE: begin
        cnt_r  <= '0;
        pres_r <= cur_r.vid_ok && eff_p;
        defd_r <= cur_r.vid_ok && eff_p && eff.defined;
      end
      ST_SCAN: begin
        cnt_r <= cnt_r + IDW'(1);
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
    if (scan_v_r) begin
      live_r[scan_idx_r]  <= scan_live;
      entry_r[scan_idx_r] <= scan_p && !rdata_r.defined;
      exit_r[scan_idx_r]  <= scan_p && rdata_r.live_out;
    end
  end

  assign out_value_present = pres_r;
  assign out_value_defined = defd_r;
  assign out_live_mask     = live_r;
  assign out_entry_mask    = entry_r;
  assign out_exit_mask     = exit_r;

endmodule
`default_nettype wire

[src/block_live_range_table_core.sv]
// Block live-range table: a request passes through the read, update, scan, drain and output
// states of the back end; the next request is not started until the result has been taken.
// Most of the work is the mask scan, which reads the table memory through its single read
// port one entry per cycle.
// The front queue holds two more requests meanwhile. Reset is synchronous and clears the
// present bits at once, so the table is empty right after reset with no clearing pass.
`default_nettype none
module block_live_range_table_core
  import lrt_pkg::*;
#(
  parameter int VALUE_COUNT = VALUE_COUNT_DEF,
  parameter int MAX_INSTRS  = MAX_INSTRS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OP_W-1:0]   in_operation,
  input  wire logic [VID_W-1:0]  in_value_id,
  input  wire logic [IDX_W-1:0]  in_instr_index,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_value_present,
  output logic                   out_value_defined,
  output logic [MASK_W-1:0]      out_live_mask,
  output logic [MASK_W-1:0]      out_entry_mask,
  output logic [MASK_W-1:0]      out_exit_mask
);

  queue_head_t head;
  logic        pop;

  lrt_front #(
    .VALUE_COUNT (VALUE_COUNT),
    .MAX_INSTRS  (MAX_INSTRS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_value_id    (in_value_id),
    .in_instr_index (in_instr_index),
    .head           (head),
    .pop            (pop)
  );

  lrt_back #(
    .VALUE_COUNT (VALUE_COUNT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_value_present (out_value_present),
    .out_value_defined (out_value_defined),
    .out_live_mask     (out_live_mask),
    .out_entry_mask    (out_entry_mask),
    .out_exit_mask     (out_exit_mask)
  );

endmodule
`default_nettype wire
